// File: src/bounded_ordered_list_top_macros.svh
// Assertion macros for the checker file of the ordered list block.
`ifndef BOUNDED_ORDERED_LIST_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_TOP_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BOL_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the block clock and reset.
`define BOL_ASSERT(name, prop, msg) \
  `BOL_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: src/bol_pkg.sv
// Types and constants of the bounded ordered list block.
package bol_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned STAT_W  = 2;

  // stream widths, whole bytes
  localparam int unsigned S_TDATA_W = 40;  // position + value, zero padded
  localparam int unsigned M_TDATA_W = 104; // 3 values + total + empty + status

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_POS  = 3'd1,
    ACT_INS_END  = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_POS  = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic                     is_empty;
    logic [TOTAL_W-1:0]       entry_total;
    logic signed [DATA_W-1:0] tail_value;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] removed_value;
  } result_t;

endpackage

// File: src/bol_core.sv
// List storage, entry count and the insert/remove/clear step applied on step_i.
module bol_core #(
  parameter int unsigned LIST_DEPTH = bol_pkg::LIST_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  bol_pkg::item_t   item_i,
  output bol_pkg::result_t res_o
);

  localparam int unsigned IW   = $clog2(LIST_DEPTH);
  localparam int unsigned CW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMPW = (CW > bol_pkg::POS_W) ? CW : bol_pkg::POS_W;
  localparam int unsigned DW   = bol_pkg::DATA_W;

  logic signed [DW-1:0] ent_q [LIST_DEPTH];
  logic signed [DW-1:0] ent_d [LIST_DEPTH];
  logic [CW-1:0]        count_q, count_d;

  logic                 is_ins, is_rem, is_clr;
  logic                 ins_ok, rem_ok;
  logic [CMPW-1:0]      tgt, cnt_ext;
  logic [IW-1:0]        tgt_idx;
  logic [CW-1:0]        cnt_m1, cnt_m2;
  logic                 full, empty;
  bol_pkg::status_e     status;
  logic signed [DW-1:0] removed, head_n, tail_n;

  // decode and checks
  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_clr  = 1'b0;
    cnt_ext = CMPW'(count_q);
    tgt     = '0;
    unique case (bol_pkg::action_e'(item_i.action))
      bol_pkg::ACT_INS_HEAD: begin
        is_ins = 1'b1;
      end
      bol_pkg::ACT_INS_POS: begin
        is_ins = 1'b1;
        tgt    = CMPW'(item_i.position);
      end
      bol_pkg::ACT_INS_END: begin
        is_ins = 1'b1;
        tgt    = cnt_ext;
      end
      bol_pkg::ACT_REM_HEAD: begin
        is_rem = 1'b1;
      end
      bol_pkg::ACT_REM_POS: begin
        is_rem = 1'b1;
        tgt    = CMPW'(item_i.position);
      end
      bol_pkg::ACT_CLEAR: begin
        is_clr = 1'b1;
      end
      default: begin
      end
    endcase

    full    = (count_q == CW'(LIST_DEPTH));
    empty   = (count_q == '0);
    tgt_idx = tgt[IW-1:0];
    cnt_m1  = count_q - CW'(1);
    cnt_m2  = count_q - CW'(2);

    status = bol_pkg::ST_OK;
    if (is_ins) begin
      if (full)                status = bol_pkg::ST_FULL;
      else if (tgt > cnt_ext)  status = bol_pkg::ST_RANGE;
    end else if (is_rem) begin
      if (empty)               status = bol_pkg::ST_EMPTY;
      else if (tgt >= cnt_ext) status = bol_pkg::ST_RANGE;
    end
    ins_ok = is_ins && (status == bol_pkg::ST_OK);
    rem_ok = is_rem && (status == bol_pkg::ST_OK);
  end

  // next list contents: every entry shifts, loads or holds in parallel
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (ins_ok) begin
      for (int i = 1; i < LIST_DEPTH; i++) begin
        if (CMPW'(i) > tgt) ent_d[i] = ent_q[i-1];
      end
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (CMPW'(i) == tgt) ent_d[i] = item_i.value;
      end
    end else if (rem_ok) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        if (CMPW'(i) >= tgt) ent_d[i] = ent_q[i+1];
      end
    end
  end

  // count, head, tail and removed value from the old contents
  always_comb begin
    count_d = count_q;
    removed = '0;
    head_n  = empty ? '0 : ent_q[0];
    tail_n  = empty ? '0 : ent_q[cnt_m1[IW-1:0]];
    if (ins_ok) begin
      count_d = count_q + CW'(1);
      head_n  = (tgt == '0) ? item_i.value : ent_q[0];
      tail_n  = (tgt == cnt_ext) ? item_i.value : ent_q[cnt_m1[IW-1:0]];
    end else if (rem_ok) begin
      count_d = cnt_m1;
      removed = ent_q[tgt_idx];
      if (cnt_m1 == '0) begin
        head_n = '0;
        tail_n = '0;
      end else begin
        head_n = (tgt == '0) ? ent_q[1] : ent_q[0];
        tail_n = (tgt == CMPW'(cnt_m1)) ? ent_q[cnt_m2[IW-1:0]]
                                        : ent_q[cnt_m1[IW-1:0]];
      end
    end else if (is_clr) begin
      count_d = '0;
      head_n  = '0;
      tail_n  = '0;
    end
  end

  always_comb begin
    res_o.status        = status;
    res_o.is_empty      = (count_d == '0);
    res_o.entry_total   = bol_pkg::TOTAL_W'(count_d);
    res_o.tail_value    = tail_n;
    res_o.head_value    = head_n;
    res_o.removed_value = removed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  // entries above the count are never read, so no reset
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        ent_q[i] <= ent_d[i];
      end
    end
  end

endmodule

// File: src/bounded_ordered_list_top.sv
// Top level of the bounded ordered list: stream ports, input and result registers.
//
// Ordered list of up to LIST_DEPTH signed 32-bit values, position 0 at the head.
// Slave channel (s_axis): one item per list action. tuser carries the action
// (insert head/at position/at end, remove head/at position, clear), tdata the
// position and the value to insert.
// Master channel (m_axis): exactly one result item per input item, in order:
// removed value (zero if none), head and tail after the action, entry total,
// empty flag and status (ok, remove on empty, insert when full, bad position).
// A failed action leaves the list unchanged.
// An accepted item sits in the input register. When it moves on, it is applied
// to the list and its result is loaded into the result register, valid on m_axis
// from then on; while the result register stays full, the item waits.
// Throughput: one item per cycle while results are taken; the whole shift of the
// entry row, the head and tail selection and the status checks fit between the
// input register and the result register.
// Reset empties the list (count to zero) and drops any item in flight.
// When the receiver stalls, the result is held; the input register still takes
// one more item, after which s_axis_tready goes low until the result is taken.
module bounded_ordered_list_top #(
  parameter int unsigned LIST_DEPTH = bol_pkg::LIST_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [4:0] position, [36:5] value, [39:37] zero
  input  logic [bol_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] action
  input  logic [bol_pkg::ACT_W-1:0]       s_axis_tuser,
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] removed_value, [63:32] head_value, [95:64] tail_value,
  // [100:96] entry_total, [101] is_empty, [103:102] status
  output logic [bol_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  logic             in_vld_q;
  bol_pkg::item_t   in_q;
  logic             out_vld_q;
  bol_pkg::result_t res_q;
  bol_pkg::result_t res_d;
  logic             advance;

  // the held item moves on when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.action   <= s_axis_tuser;
      in_q.position <= s_axis_tdata[bol_pkg::POS_W-1:0];
      in_q.value    <= s_axis_tdata[bol_pkg::POS_W +: bol_pkg::DATA_W];
    end
    if (advance) res_q <= res_d;
  end

  bol_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_q),
    .res_o (res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

endmodule

// File: src/bol_checker.sv
// Port-level checker for the bounded ordered list, bound to the top level.
`include "bounded_ordered_list_top_macros.svh"

module bol_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bol_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [31:0] removed, head, tail;
  logic [4:0]  total;
  logic        empty;
  logic [1:0]  status;

  assign removed = m_axis_tdata[31:0];
  assign head    = m_axis_tdata[63:32];
  assign tail    = m_axis_tdata[95:64];
  assign total   = m_axis_tdata[100:96];
  assign empty   = m_axis_tdata[101];
  assign status  = m_axis_tdata[103:102];

  `BOL_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `BOL_ASSERT(a_fail_no_removed, m_axis_tvalid && status != bol_pkg::ST_OK |-> removed == '0, "failed action reports a removed value")
  `BOL_ASSERT(a_empty_zero, m_axis_tvalid && empty |-> head == '0 && tail == '0, "empty list shows nonzero head or tail")
  `BOL_ASSERT(a_single_entry, m_axis_tvalid && total == 5'd1 && !empty |-> head == tail, "one entry but head differs from tail")

endmodule

bind bounded_ordered_list_top bol_checker u_bol_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// File: verif/tb_top.sv
// Self-checking stream testbench for the bounded ordered list block.
`timescale 1ns / 1ps

module tb_top;
  import bol_pkg::*;

  localparam int unsigned LIST_DEPTH = LIST_DEPTH_DEF;
  // action codes the block must treat as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake
  localparam int unsigned HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 4;    // settle time after last result

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic [ACT_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  bounded_ordered_list_top #(.LIST_DEPTH(LIST_DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // list mirror, updated as each item is accepted
  logic [DATA_W-1:0] list_mirror [LIST_DEPTH];
  int unsigned       list_len;
  result_t           pending_results [$];
  int unsigned       mismatch_count;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_serial;   // bumped by a test to ask for a long hold-off
  int unsigned stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // List mirror
  // ---------------------------------------------------------------------------
  function automatic status_e mirror_insert(int unsigned at, logic [DATA_W-1:0] val);
    // full is checked before the position
    if (list_len >= LIST_DEPTH) return ST_FULL;
    if (at > list_len) return ST_RANGE;
    for (int unsigned i = list_len; i > at; i--) list_mirror[i] = list_mirror[i-1];
    list_mirror[at] = val;
    list_len++;
    return ST_OK;
  endfunction

  function automatic status_e mirror_remove(int unsigned at, output logic [DATA_W-1:0] taken);
    taken = '0;
    // empty wins over a bad position
    if (list_len == 0) return ST_EMPTY;
    if (at >= list_len) return ST_RANGE;
    taken = list_mirror[at];
    for (int unsigned i = at; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i+1];
    list_len--;
    return ST_OK;
  endfunction

  // Apply one accepted item to the mirror and queue the result it must produce.
  task automatic predict_list_result(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                     input logic [DATA_W-1:0] val);
    result_t           res;
    status_e           st;
    logic [DATA_W-1:0] taken;
    st    = ST_OK;
    taken = '0;
    case (act)
      ACT_INS_HEAD: st = mirror_insert(0, val);
      ACT_INS_POS:  st = mirror_insert(pos, val);
      ACT_INS_END:  st = mirror_insert(list_len, val);
      ACT_REM_HEAD: st = mirror_remove(0, taken);
      ACT_REM_POS:  st = mirror_remove(pos, taken);
      ACT_CLEAR:    list_len = 0;
      default:      st = ST_OK;  // spare codes leave the list alone
    endcase
    res.removed_value = taken;
    res.head_value    = (list_len != 0) ? list_mirror[0] : '0;
    res.tail_value    = (list_len != 0) ? list_mirror[list_len-1] : '0;
    res.entry_total   = list_len[TOTAL_W-1:0];
    res.is_empty      = (list_len == 0);
    res.status        = st;
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: drives at the falling edge, sees tready at the rising edge.
  // valid stays high between back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {{(S_TDATA_W-DATA_W-POS_W){1'b0}}, val, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_list_result(act, pos, val);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned seen_serial;
    int unsigned hold_left;
    seen_serial = 0;
    hold_left   = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_serial != seen_serial) begin
        seen_serial = hold_serial;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic int field_differs(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    int      bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        bad  = 0;
        bad += field_differs("removed_value", want.removed_value, got.removed_value);
        bad += field_differs("head_value", want.head_value, got.head_value);
        bad += field_differs("tail_value", want.tail_value, got.tail_value);
        bad += field_differs("entry_total", want.entry_total, got.entry_total);
        bad += field_differs("is_empty", want.is_empty, got.is_empty);
        bad += field_differs("status", want.status, got.status);
        if (bad != 0) mismatch_count++;
      end
    end
  end

  // Watchdog: no handshake on either side for too long ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty-list errors, extremes of value and position, every action code.
  task automatic test_edge_cases();
    send_item(ACT_REM_HEAD, 5'd0, 32'h0);
    send_item(ACT_REM_POS, 5'd0, 32'h0);
    send_item(ACT_REM_POS, 5'd31, 32'hFFFF_FFFF);      // empty beats range
    send_item(ACT_CLEAR, 5'd0, 32'h0);                 // clear on empty is ok
    send_item(ACT_INS_POS, 5'd1, 32'h1);               // past count: range
    send_item(ACT_INS_POS, 5'd0, 32'h7FFF_FFFF);
    send_item(ACT_INS_HEAD, 5'd31, 32'h8000_0000);
    send_item(ACT_INS_END, 5'd0, 32'hFFFF_FFFF);
    send_item(ACT_INS_POS, 5'd3, 32'h0);               // pos == count appends
    send_item(ACT_INS_POS, 5'd2, 32'h1234_5678);       // middle insert
    send_item(ACT_INS_POS, 5'd31, 32'hDEAD_BEEF);      // range
    send_item(ACT_REM_POS, 5'd5, 32'h0);               // pos == count: range
    send_item(ACT_REM_POS, 5'd2, 32'h0);               // middle remove
    send_item(ACT_SPARE_6, 5'd31, 32'hFFFF_FFFF);
    send_item(ACT_SPARE_7, 5'd0, 32'hA5A5_5A5A);
    send_item(ACT_REM_POS, 5'd3, 32'h0);               // last entry
    send_item(ACT_REM_HEAD, 5'd17, 32'h0);
    send_item(ACT_CLEAR, 5'd31, 32'hFFFF_FFFF);
    send_item(ACT_INS_END, 5'd0, 32'h0000_0001);       // append on empty
    send_item(ACT_REM_HEAD, 5'd0, 32'h0);
  endtask

  // Fill to capacity, hit the full error with every insert, work at the far end.
  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH; i++) send_item(ACT_INS_END, 5'd0, $urandom);
    send_item(ACT_INS_HEAD, 5'd0, 32'h1);
    send_item(ACT_INS_POS, 5'd0, 32'h2);
    send_item(ACT_INS_POS, 5'd17, 32'h3);              // full reported before range
    send_item(ACT_INS_END, 5'd0, 32'h4);
    send_item(ACT_REM_POS, POS_W'(LIST_DEPTH - 1), 32'h0);
    send_item(ACT_INS_POS, POS_W'(LIST_DEPTH - 1), 32'h8000_0000);
    send_item(ACT_REM_POS, POS_W'(LIST_DEPTH), 32'h0); // range on full list
    send_item(ACT_CLEAR, 5'd0, 32'h0);
  endtask

  // Mostly legal actions with the list drifting between empty and full;
  // the rest is noise over every code and position.
  task automatic test_random_traffic(input int unsigned count, input int unsigned s_pct,
                                     input int unsigned r_pct);
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                growing;
    int unsigned       run_left;
    int unsigned       pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    growing  = 1'b1;
    run_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (run_left == 0) begin
        growing  = ($urandom_range(1) != 0);
        run_left = $urandom_range(60, 15);
      end
      run_left--;
      pick = $urandom_range(99);
      val  = ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 32'h8000_0000
                                                                  : 32'h7FFF_FFFF)
                                      : $urandom;
      if (pick < 8) begin
        act = ACT_W'($urandom_range(7));
        pos = POS_W'($urandom_range(31));
      end else if (pick < 10) begin
        act = ACT_CLEAR;
        pos = POS_W'($urandom_range(31));
      end else if ((pick < 75) == growing) begin
        act = ACT_W'($urandom_range(ACT_INS_END, ACT_INS_HEAD));
        pos = POS_W'($urandom_range(list_len));
      end else begin
        act = ($urandom_range(1) != 0) ? ACT_REM_POS : ACT_REM_HEAD;
        pos = (list_len != 0) ? POS_W'($urandom_range(list_len - 1)) : 5'd0;
      end
      send_item(act, pos, val);
    end
  endtask

  // Receiver stops for a long stretch while items keep coming, so the block
  // backs up and drops s_axis_tready.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_serial++;
    for (int i = 0; i < 40; i++) begin
      send_item(($urandom_range(2) != 0) ? ACT_INS_HEAD : ACT_REM_POS,
                POS_W'($urandom_range(LIST_DEPTH)), $urandom);
    end
  endtask

  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    rst_ni         = 1'b0;
    list_len       = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_serial    = 0;
    for (int i = 0; i < LIST_DEPTH; i++) list_mirror[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 63;
    test_edge_cases();
    test_full_list();
    test_random_traffic(480, 38, 63);
    test_random_traffic(480, 63, 38);
    test_backpressure();
    test_random_traffic(500, 0, 0);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    recv_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
